[design/light_ramp_dimmer_core_assert.svh]
// assertion macros for the checker file of the light ramp dimmer
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef LIGHT_RAMP_DIMMER_CORE_ASSERT_SVH
`define LIGHT_RAMP_DIMMER_CORE_ASSERT_SVH

// same-cycle implication, off while reset is held
`define LRD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define LRD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/lrd_pkg.sv]
// types, constants and divider step functions of the light ramp dimmer
// no dependencies; imported by the core and its checker
package lrd_pkg;

    localparam int MIN_W            = 11;
    localparam int RAMP_W           = 6;
    localparam int LVL_W            = 8;
    localparam int PH_W             = 3;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 11;
    localparam int NUM_W            = RAMP_W + LVL_W;
    localparam int S_TDATA_W        = ((MIN_W + 7) / 8) * 8;
    localparam int M_TDATA_W        = ((LVL_W + 7) / 8) * 8;
    localparam int MAX_RAMP_MINUTES = 60;

    localparam logic [LVL_W-1:0] FULL_LEVEL = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ON_MINUTE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_MINUTE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_MINUTES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_MODE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MANUAL_LEVEL = 3'd4;

    typedef enum logic [PH_W-1:0] {
        PH_MANUAL  = 3'd0,
        PH_OFF     = 3'd1,
        PH_RISING  = 3'd2,
        PH_FULL    = 3'd3,
        PH_FALLING = 3'd4
    } t_phase;

    // one pipeline slot: quo holds the dividend bits still to shift in (top)
    // and the quotient bits found so far (bottom)
    typedef struct packed {
        t_phase              phase;
        logic [RAMP_W-1:0]   e;
        logic [LVL_W-1:0]    lvl;
        logic [RAMP_W-1:0]   rem;
        logic [LVL_W-1:0]    quo;
    } t_stage;

    // one restoring step: returns {new remainder, quotient bit}
    function automatic logic [RAMP_W:0] div_step(input logic [RAMP_W-1:0] rem,
                                                 input logic              b,
                                                 input logic [RAMP_W-1:0] d);
        logic [RAMP_W:0] t;
        logic [RAMP_W:0] diff;
        t    = {rem, b};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            return {diff[RAMP_W-1:0], 1'b1};
        end
        return {t[RAMP_W-1:0], 1'b0};
    endfunction

    // two restoring steps on a pipeline slot
    function automatic t_stage div_two(input t_stage s, input logic [RAMP_W-1:0] d);
        t_stage          o;
        logic [RAMP_W:0] r;
        o   = s;
        r   = div_step(o.rem, o.quo[LVL_W-1], d);
        o.rem = r[RAMP_W:1];
        o.quo = {o.quo[LVL_W-2:0], r[0]};
        r   = div_step(o.rem, o.quo[LVL_W-1], d);
        o.rem = r[RAMP_W:1];
        o.quo = {o.quo[LVL_W-2:0], r[0]};
        return o;
    endfunction

endpackage

[design/light_ramp_dimmer_core.sv]
// light ramp dimmer: minute of day in, drive level and phase code out
// depends on lrd_pkg for types, constants and the divider step functions
//
// usage
//   s_axis carries one minute of day per transfer (hour*60+minute)
//   m_axis returns one result per input: level on tdata, phase on tuser
//   the cfg channel writes one register per transfer; o_cfg_ready is always
//   high, writes are meant to happen only while no item is in flight
//   registers: 0 on minute, 1 off minute, 2 ramp minutes (low six bits 1..60,
//   other values ignored), 3 auto mode, 4 manual level; other indexes dropped
//
// timing
//   six register stages: classify, ramp numerator, three divider stages of
//   two quotient bits each, and the output register with the last two bits
//   throughput is one item per cycle while m_axis_tready is high, set by
//   the 2-bit-per-stage divider
//   each stage has its own valid bit and load enable, so bubbles close up and
//   input keeps flowing while a result waits, until all six stages are full
//
// reset
//   synchronous active-low reset clears all valid bits and loads the register
//   defaults: on 0, off 0, ramp 1, manual mode, manual level 0
module light_ramp_dimmer_core
    import lrd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [10:0] now_minute, rest zero
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [7:0] level
    output logic [PH_W-1:0]       m_axis_tuser,   // [2:0] phase
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NSTG = 6;   // stages including the output register

    // configuration registers
    logic [MIN_W-1:0]  r_on_minute;
    logic [MIN_W-1:0]  r_off_minute;
    logic [RAMP_W-1:0] r_ramp_minutes;
    logic              r_auto_mode;
    logic [LVL_W-1:0]  r_manual_level;

    // pipeline
    logic [NSTG-1:0]   r_v;
    logic [NSTG-1:0]   w_en;
    t_stage            r_st [NSTG-1];
    t_stage            n_st [NSTG-1];
    logic [LVL_W-1:0]  r_out_level;
    t_phase            r_out_phase;
    logic [LVL_W-1:0]  n_out_level;
    t_phase            n_out_phase;

    // stage 0 classification
    logic [MIN_W-1:0]  w_now;
    logic [MIN_W:0]    w_on_p_ramp;
    logic [MIN_W:0]    w_now_p_ramp;
    logic [MIN_W:0]    w_fall_diff;
    logic [MIN_W-1:0]  w_rise_diff;
    logic              w_rising;
    logic              w_falling;
    logic              w_full;
    logic [NUM_W-1:0]  w_num;
    t_stage            w_last;

    assign o_cfg_ready = 1'b1;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_minute    <= '0;
            r_off_minute   <= '0;
            r_ramp_minutes <= RAMP_W'(1);
            r_auto_mode    <= 1'b0;
            r_manual_level <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ON_MINUTE:    r_on_minute    <= i_cfg_data[MIN_W-1:0];
                REG_OFF_MINUTE:   r_off_minute   <= i_cfg_data[MIN_W-1:0];
                REG_RAMP_MINUTES: begin
                    // out-of-range ramp lengths leave the register alone
                    if (i_cfg_data[RAMP_W-1:0] != '0 &&
                        i_cfg_data[RAMP_W-1:0] <= RAMP_W'(MAX_RAMP_MINUTES)) begin
                        r_ramp_minutes <= i_cfg_data[RAMP_W-1:0];
                    end
                end
                REG_AUTO_MODE:    r_auto_mode    <= i_cfg_data[0];
                REG_MANUAL_LEVEL: r_manual_level <= i_cfg_data[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    // a stage loads when it is empty or its content moves on
    always_comb begin
        w_en[NSTG-1] = !r_v[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign s_axis_tready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ---------------- stage 0: classify ----------------
    // all compares rewritten with the ramp added on the other side, so no
    // value goes negative; same result as the signed form with no midnight wrap
    assign w_now        = s_axis_tdata[MIN_W-1:0];
    assign w_on_p_ramp  = {1'b0, r_on_minute} + {{(MIN_W+1-RAMP_W){1'b0}}, r_ramp_minutes};
    assign w_now_p_ramp = {1'b0, w_now} + {{(MIN_W+1-RAMP_W){1'b0}}, r_ramp_minutes};
    assign w_fall_diff  = w_now_p_ramp - {1'b0, r_off_minute};
    assign w_rise_diff  = w_now - r_on_minute;

    assign w_rising  = (w_now > r_on_minute) && ({1'b0, w_now} <= w_on_p_ramp);
    assign w_falling = (w_now_p_ramp >= {1'b0, r_off_minute}) && (w_now < r_off_minute);
    assign w_full    = ({1'b0, w_now} > w_on_p_ramp) &&
                       (w_now_p_ramp < {1'b0, r_off_minute});

    always_comb begin
        n_st[0]     = '0;
        n_st[0].phase = PH_OFF;
        if (!r_auto_mode) begin
            n_st[0].phase = PH_MANUAL;
            n_st[0].lvl   = r_manual_level;
        end else if (w_rising) begin
            n_st[0].phase = PH_RISING;
            n_st[0].e     = w_rise_diff[RAMP_W-1:0];
        end else if (w_falling) begin
            n_st[0].phase = PH_FALLING;
            n_st[0].e     = w_fall_diff[RAMP_W-1:0];
        end else if (w_full) begin
            n_st[0].phase = PH_FULL;
            n_st[0].lvl   = FULL_LEVEL;
        end
    end

    // ---------------- stage 1: numerator e*255 ----------------
    // the quotient stays below 256, so the top bits already form a remainder
    // smaller than the divisor and only the low eight bits need steps
    assign w_num = {r_st[0].e, {LVL_W{1'b0}}} - {{LVL_W{1'b0}}, r_st[0].e};

    always_comb begin
        n_st[1]     = r_st[0];
        n_st[1].rem = w_num[NUM_W-1:LVL_W];
        n_st[1].quo = w_num[LVL_W-1:0];
    end

    // ---------------- stages 2..4: divider ----------------
    for (genvar k = 2; k < NSTG - 1; k++) begin : g_div
        always_comb begin
            n_st[k] = div_two(r_st[k-1], r_ramp_minutes);
        end
    end

    // ---------------- stage 5: last bits and level select ----------------
    assign w_last = div_two(r_st[NSTG-2], r_ramp_minutes);

    always_comb begin
        n_out_phase = w_last.phase;
        case (w_last.phase)
            PH_RISING:  n_out_level = w_last.quo;
            PH_FALLING: n_out_level = FULL_LEVEL - w_last.quo;
            default:    n_out_level = w_last.lvl;
        endcase
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_en[0] && s_axis_tvalid) begin
            r_st[0] <= n_st[0];
        end
        for (int k = 1; k < NSTG - 1; k++) begin
            if (w_en[k] && r_v[k-1]) begin
                r_st[k] <= n_st[k];
            end
        end
        if (w_en[NSTG-1] && r_v[NSTG-2]) begin
            r_out_level <= n_out_level;
            r_out_phase <= n_out_phase;
        end
    end

    assign m_axis_tvalid = r_v[NSTG-1];
    assign m_axis_tdata  = M_TDATA_W'(r_out_level);
    assign m_axis_tuser  = r_out_phase;

endmodule

[design/lrd_checker.sv]
// port-level checker for the light ramp dimmer, bound to the top level
// depends on lrd_pkg and light_ramp_dimmer_core_assert.svh
`include "light_ramp_dimmer_core_assert.svh"

module lrd_checker
    import lrd_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [PH_W-1:0]      m_axis_tuser
);

    // a stalled result holds its value
    `LRD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // input only backs up when the output is stalled
    `LRD_ASSERT_IMP(a_in_stall, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output stall")

    // full phase always drives full level
    `LRD_ASSERT_IMP(a_full_lvl, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == PH_FULL, m_axis_tdata[LVL_W-1:0] == FULL_LEVEL, "full phase without full level")

    // off phase always drives zero
    `LRD_ASSERT_IMP(a_off_lvl, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == PH_OFF, m_axis_tdata[LVL_W-1:0] == '0, "off phase with nonzero level")

endmodule

bind light_ramp_dimmer_core lrd_checker u_lrd_checker (.*);
